FILE: hdl/epwc_pkg.sv
package epwc_pkg;

    // Alpha is given in 1/256 units whatever the fixed-point format
    localparam int ALPHA_BITS = 8;
    localparam logic [ALPHA_BITS:0] ALPHA_ONE = 9'd256;

    // Width used for range and threshold comparisons (covers sample widths up to 17 bits)
    localparam int CMP_W = 17;
    localparam logic [CMP_W-1:0] RANGE_LOW  = 17'd50;
    localparam logic [CMP_W-1:0] RANGE_HIGH = 17'd1000;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CARD_LOW   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CARD_HIGH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PING_TO    = 3'd6;

    // Operation codes of an input item
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_PING   = 2'd1;
    localparam logic [1:0] OP_RESUME = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_PASS     = 3'd1,
        EV_PASS_OVR = 3'd2,
        EV_EMPTY    = 3'd3,
        EV_DOUBLE   = 3'd4,
        EV_WATCHDOG = 3'd5,
        EV_RANGE    = 3'd6,
        EV_RESUMED  = 3'd7
    } t_event;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_MEAS  = 2'd1,
        PH_FAULT = 2'd2
    } t_phase;

    typedef struct packed {
        logic [9:0]  card_low;
        logic [9:0]  card_high;
        logic        reverse;
        logic        override;
        logic [8:0]  alpha;
        logic [9:0]  debounce_ms;
        logic [15:0] ping_timeout_ms;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        card_low:        10'd150,
        card_high:       10'd800,
        reverse:         1'b0,
        override:        1'b0,
        alpha:           9'd51,
        debounce_ms:     10'd10,
        ping_timeout_ms: 16'd2000
    };

endpackage

FILE: hdl/epwc_in_if.sv
interface epwc_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             op;
    logic [31:0]            time_ms;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   envelope_level;

    modport source (
        output valid, op, time_ms, raw_sample, envelope_level,
        input  ready
    );

    modport sink (
        input  valid, op, time_ms, raw_sample, envelope_level,
        output ready
    );
endinterface

FILE: hdl/epwc_out_if.sv
interface epwc_out_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] filtered_value;
    logic                   envelope_present;
    logic                   stop_active;
    logic [2:0]             event_code;
    logic [SAMPLE_BITS-1:0] peak_value;

    modport source (
        output valid, filtered_value, envelope_present, stop_active, event_code,
               peak_value,
        input  ready
    );

    modport sink (
        input  valid, filtered_value, envelope_present, stop_active, event_code,
               peak_value,
        output ready
    );
endinterface

FILE: hdl/epwc_engine.sv
module epwc_engine
    import epwc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_fire,
    input  logic [1:0]             i_op,
    input  logic [31:0]            i_time_ms,
    input  logic [SAMPLE_BITS-1:0] i_raw_sample,
    input  logic                   i_envelope_level,
    input  t_cfg                   i_cfg,
    output logic [SAMPLE_BITS-1:0] o_filtered_value,
    output logic                   o_envelope_present,
    output logic                   o_stop_active,
    output t_event                 o_event_code,
    output logic [SAMPLE_BITS-1:0] o_peak_value
);

    localparam int AVG_W  = SAMPLE_BITS + FRACTION_BITS;
    localparam int PROD_W = AVG_W + ALPHA_BITS + 1;
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ALPHA_BITS - 1);

    // State
    logic [AVG_W-1:0]       r_avg, n_avg;
    logic                   r_seed, n_seed;
    logic                   r_env_seed, n_env_seed;
    logic                   r_stable, n_stable;
    logic                   r_prev, n_prev;
    logic [31:0]            r_chg_time, n_chg_time;
    logic [31:0]            r_ping_time, n_ping_time;
    t_phase                 r_phase, n_phase;
    logic [SAMPLE_BITS-1:0] r_peak, n_peak;
    logic                   r_fault, n_fault;
    t_event                 n_event;

    // Datapath signals
    logic [SAMPLE_BITS-1:0] cond_sample;
    logic [AVG_W-1:0]       cond_fixed;
    logic [ALPHA_BITS:0]    alpha_eff;
    logic [ALPHA_BITS:0]    alpha_inv;
    logic [PROD_W-1:0]      prod_new;
    logic [PROD_W-1:0]      prod_old;
    logic [PROD_W-1:0]      blend_sum;
    logic [AVG_W-1:0]       smp_avg;
    logic [SAMPLE_BITS-1:0] smp_filt;
    logic [CMP_W-1:0]       filt_cmp;
    logic                   ping_late;
    logic                   out_of_range;
    logic [31:0]            deb_chg_time;
    logic [31:0]            deb_elapsed;
    logic                   deb_settled;
    logic [SAMPLE_BITS-1:0] peak_upd;
    logic [CMP_W-1:0]       peak_cmp;
    logic                   peak_low;
    logic                   peak_high;

    // Condition the sample: optional reversal against full scale
    assign cond_sample = i_cfg.reverse ? ~i_raw_sample : i_raw_sample;
    assign cond_fixed  = {cond_sample, {FRACTION_BITS{1'b0}}};

    // Exponential average, rounded half up; alpha above one counts as one
    assign alpha_eff = (i_cfg.alpha > ALPHA_ONE) ? ALPHA_ONE : i_cfg.alpha;
    assign alpha_inv = ALPHA_ONE - alpha_eff;
    assign prod_new  = PROD_W'(alpha_eff) * PROD_W'(cond_fixed);
    assign prod_old  = PROD_W'(alpha_inv) * PROD_W'(r_avg);
    assign blend_sum = prod_new + prod_old + ROUND_HALF;
    assign smp_avg   = r_seed ? cond_fixed : blend_sum[ALPHA_BITS +: AVG_W];
    assign smp_filt  = smp_avg[FRACTION_BITS +: SAMPLE_BITS];

    // Watchdog and range checks
    assign filt_cmp     = CMP_W'(smp_filt);
    assign ping_late    = (i_time_ms - r_ping_time) > 32'(i_cfg.ping_timeout_ms);
    assign out_of_range = (filt_cmp < RANGE_LOW) || (filt_cmp > RANGE_HIGH);

    // Debounce timing against the change time as updated by this sample
    assign deb_chg_time = (i_envelope_level != r_prev) ? i_time_ms : r_chg_time;
    assign deb_elapsed  = i_time_ms - deb_chg_time;
    assign deb_settled  = deb_elapsed > 32'(i_cfg.debounce_ms);

    // Peak tracking and classification against thresholds
    assign peak_upd  = (smp_filt > r_peak) ? smp_filt : r_peak;
    assign peak_cmp  = CMP_W'(peak_upd);
    assign peak_low  = peak_cmp < CMP_W'(i_cfg.card_low);
    assign peak_high = peak_cmp > CMP_W'(i_cfg.card_high);

    // Next state for one item
    always_comb begin
        n_avg       = r_avg;
        n_seed      = r_seed;
        n_env_seed  = r_env_seed;
        n_stable    = r_stable;
        n_prev      = r_prev;
        n_chg_time  = r_chg_time;
        n_ping_time = r_ping_time;
        n_phase     = r_phase;
        n_peak      = r_peak;
        n_fault     = r_fault;
        n_event     = EV_NONE;

        unique case (i_op)
            OP_PING: begin
                n_ping_time = i_time_ms;
            end
            OP_RESUME: begin
                n_fault = 1'b0;
                n_phase = PH_IDLE;
                n_avg   = cond_fixed;
                n_seed  = 1'b0;
                n_event = EV_RESUMED;
            end
            OP_SAMPLE: begin
                n_avg  = smp_avg;
                n_seed = 1'b0;

                // Latch a fault: watchdog first, then range
                if (!i_cfg.override) begin
                    if (ping_late && !n_fault) begin
                        n_fault = 1'b1;
                        n_phase = PH_FAULT;
                        n_event = EV_WATCHDOG;
                    end
                    if (out_of_range && !n_fault) begin
                        n_fault = 1'b1;
                        n_phase = PH_FAULT;
                        n_event = EV_RANGE;
                    end
                end

                // Debounce the envelope line; the first sample seeds it
                if (r_env_seed) begin
                    n_stable   = i_envelope_level;
                    n_prev     = i_envelope_level;
                    n_chg_time = i_time_ms;
                    n_env_seed = 1'b0;
                end else begin
                    n_prev     = i_envelope_level;
                    n_chg_time = deb_chg_time;
                    if (deb_settled) begin
                        n_stable = i_envelope_level;
                    end
                end

                // Open, track and close the envelope window
                unique case (n_phase)
                    PH_IDLE: begin
                        if (!n_stable) begin
                            n_phase = PH_MEAS;
                            n_peak  = '0;
                        end
                    end
                    PH_MEAS: begin
                        n_peak = peak_upd;
                        if (n_stable) begin
                            n_phase = PH_IDLE;
                            if (!peak_low && !peak_high) begin
                                n_event = EV_PASS;
                            end else if (i_cfg.override) begin
                                n_event = EV_PASS_OVR;
                            end else begin
                                n_fault = 1'b1;
                                if (peak_low) begin
                                    n_event = EV_EMPTY;
                                end else begin
                                    n_event = EV_DOUBLE;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Advance the state on each item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg       <= '0;
            r_seed      <= 1'b1;
            r_env_seed  <= 1'b1;
            r_stable    <= 1'b1;
            r_prev      <= 1'b1;
            r_chg_time  <= '0;
            r_ping_time <= '0;
            r_phase     <= PH_IDLE;
            r_peak      <= '0;
            r_fault     <= 1'b0;
        end else if (i_fire) begin
            r_avg       <= n_avg;
            r_seed      <= n_seed;
            r_env_seed  <= n_env_seed;
            r_stable    <= n_stable;
            r_prev      <= n_prev;
            r_chg_time  <= n_chg_time;
            r_ping_time <= n_ping_time;
            r_phase     <= n_phase;
            r_peak      <= n_peak;
            r_fault     <= n_fault;
        end
    end

    assign o_filtered_value   = n_avg[FRACTION_BITS +: SAMPLE_BITS];
    assign o_envelope_present = !n_stable;
    assign o_stop_active      = n_fault;
    assign o_event_code       = n_event;
    assign o_peak_value       = n_peak;

endmodule

FILE: hdl/envelope_peak_window_checker_core.sv
// Pipeline: an item taken into the input register passes through the engine
// into the result register, which drives o_result.
// Throughput: one item per cycle unless o_result stalls; the state update sits
// in the single stage between the input register and the result register.
// Reset: synchronous, active low; clears the pipeline, the state and loads the
// default settings.
module envelope_peak_window_checker_core
    import epwc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int FRACTION_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    epwc_in_if.sink               i_item,
    epwc_out_if.source            o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic                   r_in_valid;
    logic [1:0]             r_in_op;
    logic [31:0]            r_in_time;
    logic [SAMPLE_BITS-1:0] r_in_raw;
    logic                   r_in_level;

    logic                   r_out_valid;
    logic [SAMPLE_BITS-1:0] r_out_filt;
    logic                   r_out_present;
    logic                   r_out_stop;
    t_event                 r_out_event;
    logic [SAMPLE_BITS-1:0] r_out_peak;

    logic                   advance;
    logic                   fire;
    logic [SAMPLE_BITS-1:0] res_filt;
    logic                   res_present;
    logic                   res_stop;
    t_event                 res_event;
    logic [SAMPLE_BITS-1:0] res_peak;

    // Settings registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CARD_LOW:  r_cfg.card_low        <= i_cfg_data[9:0];
                CFG_CARD_HIGH: r_cfg.card_high       <= i_cfg_data[9:0];
                CFG_REVERSE:   r_cfg.reverse         <= i_cfg_data[0];
                CFG_OVERRIDE:  r_cfg.override        <= i_cfg_data[0];
                CFG_ALPHA:     r_cfg.alpha           <= i_cfg_data[8:0];
                CFG_DEBOUNCE:  r_cfg.debounce_ms     <= i_cfg_data[9:0];
                CFG_PING_TO:   r_cfg.ping_timeout_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline control: the stage moves when the result register is free
    assign advance      = !r_out_valid || o_result.ready;
    assign fire         = r_in_valid && advance;
    assign i_item.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in_op    <= i_item.op;
            r_in_time  <= i_item.time_ms;
            r_in_raw   <= i_item.raw_sample;
            r_in_level <= i_item.envelope_level;
        end
    end

    epwc_engine #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_engine (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_fire             (fire),
        .i_op               (r_in_op),
        .i_time_ms          (r_in_time),
        .i_raw_sample       (r_in_raw),
        .i_envelope_level   (r_in_level),
        .i_cfg              (r_cfg),
        .o_filtered_value   (res_filt),
        .o_envelope_present (res_present),
        .o_stop_active      (res_stop),
        .o_event_code       (res_event),
        .o_peak_value       (res_peak)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_filt    <= res_filt;
            r_out_present <= res_present;
            r_out_stop    <= res_stop;
            r_out_event   <= res_event;
            r_out_peak    <= res_peak;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.filtered_value   = r_out_filt;
    assign o_result.envelope_present = r_out_present;
    assign o_result.stop_active      = r_out_stop;
    assign o_result.event_code       = r_out_event;
    assign o_result.peak_value       = r_out_peak;

endmodule
